>>> rtl/core/bls_pkg.sv
// Shared types and constants for the box least squares search unit.
// No dependencies; imported by bls_div, bls_mul and the search unit.
package bls_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EVAL    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  localparam int DIV_NW = 112;   // numerator width: (|S|^2) << 8
  localparam int DIV_DW = 73;    // denominator width: R * |1 - R|
  localparam int MUL_W  = 52;    // operand width of the shift-add multiplier
  localparam int CNT_W  = 7;     // step counter width for both units

  localparam int R_W  = 37;
  localparam int S_W  = 53;
  localparam int WX_W = 51;

  localparam logic [R_W-1:0] ONE_Q24 = R_W'(1) << 24;
  localparam logic [63:0] Q_LIMIT = 64'h4000_0000_0000_0000;
  localparam logic signed [47:0] D_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] D_MIN = 48'sh8000_0000_0000;

endpackage

>>> rtl/core/bls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bls_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/bls_div.sv
// Shared restoring divider, one quotient bit per cycle, MSB first.
// Serves the per-sample time fold and the final quotient. Uses bls_pkg.
module bls_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bls_pkg::DIV_NW-1:0] num,
  input  logic [bls_pkg::DIV_DW-1:0] den,
  input  logic [bls_pkg::CNT_W-1:0]  steps,
  output logic                       done,
  output logic [bls_pkg::DIV_DW-1:0] rem,
  output logic [63:0]                quo,
  output logic                       ovf
);
  import bls_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_NW-1:0] nsh;
  logic [DIV_DW-1:0] dreg;
  logic [DIV_DW:0]   rem_s;
  logic              take;

  assign rem_s = {rem, nsh[DIV_NW-1]};
  assign take  = rem_s >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
        nsh  <= num;
        dreg <= den;
        rem  <= '0;
        quo  <= '0;
        ovf  <= 1'b0;
      end else if (busy) begin
        rem  <= take ? DIV_DW'(rem_s - {1'b0, dreg}) : DIV_DW'(rem_s);
        nsh  <= nsh << 1;
        quo  <= {quo[62:0], take};
        ovf  <= ovf | quo[63];
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/bls_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Forms |S|^2 and R * |1 - R| for the final step. Uses bls_pkg.
module bls_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bls_pkg::MUL_W-1:0]   a,
  input  logic [bls_pkg::MUL_W-1:0]   b,
  output logic                        done,
  output logic [2*bls_pkg::MUL_W-1:0] prod
);
  import bls_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_W-1:0]   ash;
  logic [2*MUL_W-1:0] bsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MUL_W);
        ash  <= a;
        bsh  <= (2*MUL_W)'(b);
        prod <= '0;
      end else if (busy) begin
        if (ash[0]) begin
          prod <= prod + bsh;
        end
        ash <= ash >> 1;
        bsh <= bsh << 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/box_least_squares_search_unit.sv
// Box least squares search unit: sample store, trial sequencer, best tracking.
// Depends on bls_pkg, bls_ram, bls_div and bls_mul.
//
// Loads and restarts complete on acceptance in the idle state. An evaluation
// walks the first min(sample_count, SAMPLES) stored samples, n of them; each
// sample takes a store read and a 32-step time fold in the shared divider.
// A non-degenerate trial then runs two multiplies and a final divide before
// its result is valid; a degenerate trial goes straight to the result.
// The input is not ready while a trial runs; a finished
// result waits in the output register while the next transaction is taken.
module box_least_squares_search_unit #(
  parameter int SAMPLES = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [12:0]  cfg_wdata,       // sample_count
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [11:0] sample_index, [43:12] sample_time, [59:44] sample_flux,
  // [83:60] sample_weight, [115:84] trial_period, [147:116] trial_duration,
  // [179:148] trial_phase, [183:180] zero
  input  logic [183:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,    // [1:0] operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [47:0] d_value, [95:48] best_d, [127:96] best trial period,
  // [159:128] best trial duration, [191:160] best trial phase
  output logic [191:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser     // [0] degenerate, [1] best_found
);
  import bls_pkg::*;

  localparam int AW = $clog2(SAMPLES);
  localparam int CW = $clog2(SAMPLES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL1, S_MOD, S_FIN, S_MSQ, S_MDEN, S_DIV, S_DCALC, S_OUT
  } state_t;

  state_t state;
  logic [12:0] sample_count;
  logic [CW-1:0] n_lim, idx;
  logic [31:0] period, duration, phase;
  logic [32:0] top;
  logic [23:0] w_l;
  logic signed [15:0] f_l;
  logic signed [31:0] ff;
  logic signed [40:0] wf;
  logic [54:0] wff;
  logic [R_W-1:0] r_sum;
  logic signed [S_W-1:0] s_sum;
  logic [WX_W-1:0] wx_sum;
  logic [DIV_NW-1:0] num;
  logic [62:0] qs;
  logic signed [47:0] d_val, best_stat;
  logic degen;
  logic [31:0] keep_period, keep_duration, keep_phase;
  logic found;

  logic accept, ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [71:0] ram_rdata;
  logic [31:0] idx32;

  logic mul_start, mul_done;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_prod;
  logic div_start, div_done, div_ovf;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den, div_rem;
  logic [CNT_W-1:0] div_steps;
  logic [63:0] div_quo;

  logic [31:0] m;
  logic in_box;
  logic [S_W-1:0] sa;
  logic [R_W-1:0] other;
  logic signed [64:0] dw;
  logic degen_now;
  logic out_fire;

  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign idx32 = {20'b0, s_axis_tdata[11:0]};
  assign ram_we = accept && (op_t'(s_axis_tuser) == OP_LOAD) && (idx32 < 32'(SAMPLES));
  assign ram_waddr = AW'(idx32);
  assign ram_re = (state == S_RD);

  bls_ram #(.WIDTH(72), .DEPTH(SAMPLES)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(s_axis_tdata[83:12]),
    .re(ram_re), .raddr(idx[AW-1:0]), .rdata(ram_rdata)
  );

  bls_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  bls_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .steps(div_steps), .done(div_done), .rem(div_rem), .quo(div_quo), .ovf(div_ovf)
  );

  assign m = div_rem[31:0];
  assign in_box = (m >= phase) && ({1'b0, m} <= top);
  assign sa = s_sum[S_W-1] ? S_W'(-s_sum) : S_W'(s_sum);
  assign other = (r_sum < ONE_Q24) ? (ONE_Q24 - r_sum) : (r_sum - ONE_Q24);
  assign dw = (r_sum < ONE_Q24) ? $signed({14'b0, wx_sum}) - $signed({2'b0, qs})
                                : $signed({14'b0, wx_sum}) + $signed({2'b0, qs});
  assign degen_now = (r_sum == '0) || (r_sum == ONE_Q24);
  assign out_fire = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = MUL_W'(sa);
    mul_b     = MUL_W'(sa);
    div_start = 1'b0;
    div_num   = {ram_rdata[31:0], (DIV_NW-32)'(0)};
    div_den   = DIV_DW'(period);
    div_steps = CNT_W'(32);
    case (state)
      S_MUL1: div_start = 1'b1;
      S_FIN:  mul_start = !degen_now;
      S_MSQ: begin
        mul_start = mul_done;
        mul_a     = MUL_W'(r_sum);
        mul_b     = MUL_W'(other);
      end
      S_MDEN: begin
        div_start = mul_done;
        div_num   = num;
        div_den   = mul_prod[DIV_DW-1:0];
        div_steps = CNT_W'(DIV_NW);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ff  <= f_l * f_l;
    wf  <= $signed({1'b0, w_l}) * f_l;
    wff <= w_l * ff[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sample_count  <= 13'd4096;
      m_axis_tvalid <= 1'b0;
      best_stat     <= D_MAX;
      keep_period   <= '0;
      keep_duration <= '0;
      keep_phase    <= '0;
      found         <= 1'b0;
    end else begin
      if (cfg_we) begin
        sample_count <= cfg_wdata;
      end
      if (out_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && op_t'(s_axis_tuser) == OP_RESTART) begin
            best_stat     <= D_MAX;
            keep_period   <= '0;
            keep_duration <= '0;
            keep_phase    <= '0;
            found         <= 1'b0;
          end
          if (accept && op_t'(s_axis_tuser) == OP_EVAL) begin
            period   <= s_axis_tdata[115:84];
            duration <= s_axis_tdata[147:116];
            phase    <= s_axis_tdata[179:148];
            top      <= {1'b0, s_axis_tdata[179:148]} + {1'b0, s_axis_tdata[147:116]};
            n_lim    <= (32'(sample_count) > 32'(SAMPLES)) ? CW'(SAMPLES) : CW'(sample_count);
            idx      <= '0;
            r_sum    <= '0;
            s_sum    <= '0;
            wx_sum   <= '0;
            state    <= (sample_count == 13'd0) ? S_FIN : S_RD;
          end
        end
        S_RD: state <= S_MUL1;
        S_MUL1: begin
          w_l   <= ram_rdata[71:48];
          f_l   <= ram_rdata[47:32];
          state <= S_MOD;
        end
        S_MOD: begin
          if (div_done) begin
            wx_sum <= wx_sum + WX_W'(wff[54:16]);
            if (in_box) begin
              r_sum <= r_sum + R_W'(w_l);
              s_sum <= s_sum + {{(S_W-41){wf[40]}}, wf};
            end
            idx   <= idx + CW'(1);
            state <= (idx + CW'(1) == n_lim) ? S_FIN : S_RD;
          end
        end
        S_FIN: begin
          degen <= degen_now;
          d_val <= '0;
          state <= degen_now ? S_OUT : S_MSQ;
        end
        S_MSQ: begin
          if (mul_done) begin
            num   <= {mul_prod[DIV_NW-9:0], 8'b0};
            state <= S_MDEN;
          end
        end
        S_MDEN: begin
          if (mul_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            qs    <= (div_ovf || div_quo > Q_LIMIT) ? Q_LIMIT[62:0] : div_quo[62:0];
            state <= S_DCALC;
          end
        end
        S_DCALC: begin
          if (dw > 65'(D_MAX)) begin
            d_val <= D_MAX;
          end else if (dw < 65'(D_MIN)) begin
            d_val <= D_MIN;
          end else begin
            d_val <= dw[47:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            m_axis_tdata[47:0] <= d_val;
            m_axis_tuser[0]    <= degen;
            if (!degen && (!found || d_val < best_stat)) begin
              best_stat             <= d_val;
              keep_period           <= period;
              keep_duration         <= duration;
              keep_phase            <= phase;
              m_axis_tdata[95:48]   <= d_val;
              m_axis_tdata[127:96]  <= period;
              m_axis_tdata[159:128] <= duration;
              m_axis_tdata[191:160] <= phase;
            end else begin
              m_axis_tdata[95:48]   <= best_stat;
              m_axis_tdata[127:96]  <= keep_period;
              m_axis_tdata[159:128] <= keep_duration;
              m_axis_tdata[191:160] <= keep_phase;
            end
            if (!degen) begin
              found <= 1'b1;
            end
            m_axis_tuser[1] <= found || !degen;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
